>>> rtl/core/pvps_pkg.sv
// Shared widths, register indexes, reset values and controller state type.
package pvps_pkg;

	// Field and datapath widths.
	localparam int POWER_W   = 24;
	localparam int FRAC_W    = 16;
	localparam int ALPHA_W   = 16;
	localparam int SOC_W     = 16;
	localparam int CFG_W     = 16;
	localparam int LIMIT_W   = POWER_W - 1;
	localparam int STATE_W   = POWER_W + FRAC_W;
	localparam int MAG_W     = STATE_W;
	localparam int PROD_W    = MAG_W + ALPHA_W;
	localparam int C_W       = MAG_W + 1;
	localparam int Q_W       = PROD_W + 1 - FRAC_W;
	localparam int MUL_CNT_W = $clog2(ALPHA_W);
	localparam int DIV_CNT_W = $clog2(PROD_W);
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOC_MIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SOC_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SOC_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SOC_MAX  = 3'd4;

	// Configuration reset values.
	localparam logic [CFG_W-1:0] ALPHA_RST    = 16'd62259;
	localparam logic [CFG_W-1:0] SOC_MIN_RST  = 16'd6554;
	localparam logic [CFG_W-1:0] SOC_LOW_RST  = 16'd13107;
	localparam logic [CFG_W-1:0] SOC_HIGH_RST = 16'd52428;
	localparam logic [CFG_W-1:0] SOC_MAX_RST  = 16'd58982;

	// Status of a serial arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

	// Controller sequence.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_FILT,
		ST_FILT_SIGN,
		ST_FILT_C,
		ST_DECIDE,
		ST_MUL_DER,
		ST_DIV,
		ST_ROUND,
		ST_FINISH
	} state_t;

endpackage

>>> rtl/core/pvps_serial_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module pvps_serial_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pvps_pkg::MAG_W-1:0]        mcand,
	input  logic [pvps_pkg::ALPHA_W-1:0]      mplier,
	output logic [pvps_pkg::PROD_W-1:0]       product,
	output pvps_pkg::unit_status_t            status
);

	logic [pvps_pkg::MAG_W-1:0]     mcand_q;
	logic [pvps_pkg::ALPHA_W-1:0]   mplier_q;
	logic [pvps_pkg::PROD_W-1:0]    acc_q;
	logic [pvps_pkg::MUL_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [pvps_pkg::PROD_W-1:0]    addend;

	// Partial product for the current multiplier bit, taken MSB first.
	assign addend = mplier_q[pvps_pkg::ALPHA_W-1] ?
		pvps_pkg::PROD_W'(mcand_q) : '0;

	// Sequencing control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pvps_pkg::MUL_CNT_W'(pvps_pkg::ALPHA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand shift register and accumulator.
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (busy_q) begin
			acc_q    <= {acc_q[pvps_pkg::PROD_W-2:0], 1'b0} + addend;
			mplier_q <= {mplier_q[pvps_pkg::ALPHA_W-2:0], 1'b0};
		end
	end

	assign product     = acc_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

>>> rtl/core/pvps_serial_div.sv
// Restoring divider, one quotient bit per cycle; the divisor is never zero.
module pvps_serial_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pvps_pkg::PROD_W-1:0]    dividend,
	input  logic [pvps_pkg::ALPHA_W-1:0]   divisor,
	output logic [pvps_pkg::PROD_W-1:0]    quotient,
	output pvps_pkg::unit_status_t         status
);

	logic [pvps_pkg::PROD_W-1:0]    quo_q;
	logic [pvps_pkg::ALPHA_W-1:0]   rem_q;
	logic [pvps_pkg::ALPHA_W-1:0]   divisor_q;
	logic [pvps_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [pvps_pkg::ALPHA_W:0]     trial;
	logic [pvps_pkg::ALPHA_W:0]     diff;
	logic                           fits;

	// Trial subtraction of the divisor from the shifted remainder.
	assign trial = {rem_q, quo_q[pvps_pkg::PROD_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	// Sequencing control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pvps_pkg::DIV_CNT_W'(pvps_pkg::PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shifts out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[pvps_pkg::ALPHA_W-1:0] : trial[pvps_pkg::ALPHA_W-1:0];
			quo_q <= {quo_q[pvps_pkg::PROD_W-2:0], fits};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

>>> rtl/core/pv_power_smoothing_controller_top.sv
// Top level of the PV power smoothing controller with SOC derating.
// One sample is taken at a time. A sample that is invalid, has smoothing
// off, or is the first after reset or after such a sample loads the
// filter; its zero command goes through the finish state into the output
// register, and the next sample is taken only after that. Otherwise the
// filter update runs on a bit-serial multiplier (one alpha bit per cycle)
// and, with the sign, rounding and decision steps, the result goes through
// the finish state into the output register. When the SOC lies in the
// derating zone for the command's direction and the derating ratio is
// positive, a second pass on the same multiplier and a restoring divider
// (one quotient bit per cycle) scale the command. The result sits in an
// output register, so the next sample is taken while it waits; a sample
// finishes only once that register is free, and waits in the finish state
// until then.
// Configuration writes take effect at once and are meant for idle periods.
module pv_power_smoothing_controller_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port.
	input  logic                                 cfg_we,
	input  logic [pvps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pvps_pkg::CFG_W-1:0]           cfg_data,
	// Sample input channel.
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [pvps_pkg::POWER_W-1:0]  pv_power,
	input  logic [pvps_pkg::SOC_W-1:0]           soc,
	input  logic [pvps_pkg::LIMIT_W-1:0]         charge_limit,
	input  logic [pvps_pkg::LIMIT_W-1:0]         discharge_limit,
	input  logic                                 charge_enable,
	input  logic                                 discharge_enable,
	input  logic                                 smoothing_enable,
	input  logic                                 sample_valid,
	// Result output channel.
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pvps_pkg::POWER_W-1:0]  compensation_power
);

	pvps_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [pvps_pkg::CFG_W-1:0] alpha_q, soc_min_q, soc_low_q, soc_high_q, soc_max_q;

	// Filter state.
	logic [pvps_pkg::STATE_W-1:0] smooth_q;
	logic                         first_q;

	// Per-sample working registers.
	logic [pvps_pkg::STATE_W-1:0]  pf_q;
	logic                          d_neg_q;
	logic [pvps_pkg::PROD_W:0]     sp_q;
	logic [pvps_pkg::C_W-1:0]      c_q;
	logic [pvps_pkg::PROD_W-1:0]   mag_q;
	logic [pvps_pkg::ALPHA_W-1:0]  ad_q;
	logic [pvps_pkg::SOC_W-1:0]    soc_q;
	logic [pvps_pkg::LIMIT_W-1:0]  chg_lim_q, dis_lim_q;
	logic                          chg_en_q, dis_en_q;
	logic [pvps_pkg::POWER_W-1:0]  res_q;

	// Output register.
	logic                          out_valid_q;
	logic [pvps_pkg::POWER_W-1:0]  out_data_q;

	// Control strobes.
	logic in_accept, bypass, mul_start, div_start, load_out, derate_go;

	// Serial unit interface.
	logic [pvps_pkg::MAG_W-1:0]   mul_mcand;
	logic [pvps_pkg::ALPHA_W-1:0] mul_mplier;
	logic [pvps_pkg::PROD_W-1:0]  mul_prod, div_quo;
	pvps_pkg::unit_status_t       mul_st, div_st;

	// Filter difference s - P and its magnitude.
	logic [pvps_pkg::STATE_W-1:0] pf_in;
	logic [pvps_pkg::C_W-1:0]     d_full, d_abs;

	assign pf_in  = {pv_power, {pvps_pkg::FRAC_W{1'b0}}};
	assign d_full = {smooth_q[pvps_pkg::STATE_W-1], smooth_q} -
		{pf_in[pvps_pkg::STATE_W-1], pf_in};
	assign d_abs  = d_full[pvps_pkg::C_W-1] ? (~d_full + 1'b1) : d_full;
	assign bypass = !sample_valid || !smoothing_enable || first_q;

	// Compensation rounding of the filter product: c = (a*d + half) >>> 16.
	logic [pvps_pkg::PROD_W:0] sp_round;
	assign sp_round = sp_q + (pvps_pkg::PROD_W + 1)'(1 << (pvps_pkg::ALPHA_W - 1));

	// Derating decision on the compensation.
	logic                         c_neg, c_pos, chg_zone, dis_zone, der_zero;
	logic [pvps_pkg::SOC_W:0]     num, den, an_full, ad_full;
	logic [pvps_pkg::C_W-1:0]     c_abs;

	assign c_neg    = c_q[pvps_pkg::C_W-1];
	assign c_pos    = !c_neg && (c_q != '0);
	assign chg_zone = (soc_q > soc_high_q) && c_neg;
	assign dis_zone = (soc_q < soc_low_q) && c_pos;
	assign num      = chg_zone ? ({1'b0, soc_max_q} - {1'b0, soc_q}) :
		({1'b0, soc_q} - {1'b0, soc_min_q});
	assign den      = chg_zone ? ({1'b0, soc_max_q} - {1'b0, soc_high_q}) :
		({1'b0, soc_low_q} - {1'b0, soc_min_q});
	assign der_zero = (den == '0) || (num == '0) ||
		(num[pvps_pkg::SOC_W] != den[pvps_pkg::SOC_W]);
	assign an_full  = num[pvps_pkg::SOC_W] ? (~num + 1'b1) : num;
	assign ad_full  = den[pvps_pkg::SOC_W] ? (~den + 1'b1) : den;
	assign c_abs    = c_neg ? (~c_q + 1'b1) : c_q;
	assign derate_go = (chg_zone || dis_zone) && !der_zero;

	// Rounding to whole power units, then limit and gate per direction.
	logic [pvps_pkg::PROD_W:0]    mag_round;
	logic [pvps_pkg::Q_W-1:0]     q_mag;
	logic                         r_neg, r_en;
	logic [pvps_pkg::LIMIT_W-1:0] r_lim, q_lim, r_mag;
	logic [pvps_pkg::POWER_W-1:0] r_val;

	assign mag_round = {1'b0, mag_q} + (pvps_pkg::PROD_W + 1)'(1 << (pvps_pkg::FRAC_W - 1));
	assign q_mag     = mag_round[pvps_pkg::PROD_W:pvps_pkg::FRAC_W];
	assign r_neg     = c_neg && (q_mag != '0);
	assign r_lim     = r_neg ? chg_lim_q : dis_lim_q;
	assign r_en      = r_neg ? chg_en_q : dis_en_q;
	assign q_lim     = (q_mag > pvps_pkg::Q_W'(r_lim)) ? r_lim : q_mag[pvps_pkg::LIMIT_W-1:0];
	assign r_mag     = r_en ? q_lim : '0;
	assign r_val     = r_neg ? (~{1'b0, r_mag} + 1'b1) : {1'b0, r_mag};

	// Serial units; the multiplier is shared by the filter and derating passes.
	pvps_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_mcand),
		.mplier  (mul_mplier),
		.product (mul_prod),
		.status  (mul_st)
	);

	pvps_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_prod),
		.divisor  (ad_q),
		.quotient (div_quo),
		.status   (div_st)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pvps_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = bypass ? pvps_pkg::ST_FINISH : pvps_pkg::ST_MUL_FILT;
				end
			end
			pvps_pkg::ST_MUL_FILT: begin
				if (mul_st.done) begin
					state_d = pvps_pkg::ST_FILT_SIGN;
				end
			end
			pvps_pkg::ST_FILT_SIGN: state_d = pvps_pkg::ST_FILT_C;
			pvps_pkg::ST_FILT_C:    state_d = pvps_pkg::ST_DECIDE;
			pvps_pkg::ST_DECIDE: begin
				state_d = derate_go ? pvps_pkg::ST_MUL_DER : pvps_pkg::ST_ROUND;
			end
			pvps_pkg::ST_MUL_DER: begin
				if (mul_st.done) begin
					state_d = pvps_pkg::ST_DIV;
				end
			end
			pvps_pkg::ST_DIV: begin
				if (div_st.done) begin
					state_d = pvps_pkg::ST_ROUND;
				end
			end
			pvps_pkg::ST_ROUND:     state_d = pvps_pkg::ST_FINISH;
			pvps_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = pvps_pkg::ST_IDLE;
				end
			end
			default: state_d = pvps_pkg::ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		in_ready   = (state_q == pvps_pkg::ST_IDLE);
		in_accept  = in_ready && in_valid;
		mul_start  = 1'b0;
		div_start  = 1'b0;
		load_out   = 1'b0;
		mul_mcand  = c_abs[pvps_pkg::MAG_W-1:0];
		mul_mplier = an_full[pvps_pkg::ALPHA_W-1:0];
		case (state_q)
			pvps_pkg::ST_IDLE: begin
				mul_start  = in_accept && !bypass;
				mul_mcand  = d_abs[pvps_pkg::MAG_W-1:0];
				mul_mplier = alpha_q;
			end
			pvps_pkg::ST_DECIDE:  mul_start = derate_go;
			pvps_pkg::ST_MUL_DER: div_start = mul_st.done;
			pvps_pkg::ST_FINISH:  load_out  = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	// Control registers, configuration and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pvps_pkg::ST_IDLE;
			alpha_q     <= pvps_pkg::ALPHA_RST;
			soc_min_q   <= pvps_pkg::SOC_MIN_RST;
			soc_low_q   <= pvps_pkg::SOC_LOW_RST;
			soc_high_q  <= pvps_pkg::SOC_HIGH_RST;
			soc_max_q   <= pvps_pkg::SOC_MAX_RST;
			smooth_q    <= '0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					pvps_pkg::CFG_ALPHA:    alpha_q    <= cfg_data;
					pvps_pkg::CFG_SOC_MIN:  soc_min_q  <= cfg_data;
					pvps_pkg::CFG_SOC_LOW:  soc_low_q  <= cfg_data;
					pvps_pkg::CFG_SOC_HIGH: soc_high_q <= cfg_data;
					pvps_pkg::CFG_SOC_MAX:  soc_max_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			// Bypassed samples reload the filter directly.
			if (in_accept && bypass) begin
				smooth_q <= pf_in;
				first_q  <= !sample_valid || !smoothing_enable;
			end
			// Filtered value is P plus the rounded compensation.
			if (state_q == pvps_pkg::ST_DECIDE) begin
				smooth_q <= pf_q + c_q[pvps_pkg::STATE_W-1:0];
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			pf_q      <= pf_in;
			d_neg_q   <= d_full[pvps_pkg::C_W-1];
			soc_q     <= soc;
			chg_lim_q <= charge_limit;
			dis_lim_q <= discharge_limit;
			chg_en_q  <= charge_enable;
			dis_en_q  <= discharge_enable;
			res_q     <= '0;
		end
		case (state_q)
			pvps_pkg::ST_FILT_SIGN: begin
				sp_q <= d_neg_q ? (~{1'b0, mul_prod} + 1'b1) : {1'b0, mul_prod};
			end
			pvps_pkg::ST_FILT_C: begin
				c_q <= sp_round[pvps_pkg::PROD_W:pvps_pkg::ALPHA_W];
			end
			pvps_pkg::ST_DECIDE: begin
				ad_q  <= ad_full[pvps_pkg::ALPHA_W-1:0];
				mag_q <= (chg_zone || dis_zone) ? '0 : pvps_pkg::PROD_W'(c_abs);
			end
			pvps_pkg::ST_DIV: begin
				if (div_st.done) begin
					mag_q <= div_quo;
				end
			end
			pvps_pkg::ST_ROUND: res_q <= r_val;
			default: begin
			end
		endcase
		if (load_out) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign compensation_power = out_data_q;

	// A multiplier result arrives only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_st.done |-> (state_q == pvps_pkg::ST_MUL_FILT || state_q == pvps_pkg::ST_MUL_DER))
		else $error("multiplier finished outside a multiply state");

	// A quotient arrives only in the divide state.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == pvps_pkg::ST_DIV))
		else $error("divider finished outside the divide state");

	// No serial unit is still running when a new sample can be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!mul_st.busy && !div_st.busy))
		else $error("serial unit busy while idle");

	// Every accepted transaction leaves the idle state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != pvps_pkg::ST_IDLE))
		else $error("accepted transaction did not start");

	// A finished result waits while the output register is still occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pvps_pkg::ST_FINISH && out_valid && !out_ready) |=>
		(state_q == pvps_pkg::ST_FINISH && out_valid))
		else $error("result overwrote an untaken output");

endmodule

>>> bench/tb.sv
// Self-checking testbench for the PV power smoothing controller with SOC derating.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// One input sample as seen on the sample channel.
	typedef struct {
		logic signed [pvps_pkg::POWER_W-1:0] pv_power;
		logic [pvps_pkg::SOC_W-1:0]          soc;
		logic [pvps_pkg::LIMIT_W-1:0]        charge_limit;
		logic [pvps_pkg::LIMIT_W-1:0]        discharge_limit;
		logic                                charge_enable;
		logic                                discharge_enable;
		logic                                smoothing_enable;
		logic                                sample_valid;
	} sample_t;

	// Enable sets for directed samples, ordered {valid, smoothing, charge, discharge}.
	localparam logic [3:0] EN_ALL       = 4'b1111;
	localparam logic [3:0] EN_NO_VALID  = 4'b0111;
	localparam logic [3:0] EN_NO_SMOOTH = 4'b1011;
	localparam logic [3:0] EN_NO_CHG    = 4'b1101;
	localparam logic [3:0] EN_NO_DIS    = 4'b1110;

	localparam logic signed [pvps_pkg::POWER_W-1:0] PV_MAX =
		{1'b0, {(pvps_pkg::POWER_W-1){1'b1}}};
	localparam logic signed [pvps_pkg::POWER_W-1:0] PV_MIN =
		{1'b1, {(pvps_pkg::POWER_W-1){1'b0}}};
	localparam logic [pvps_pkg::LIMIT_W-1:0]        LIM_MAX = '1;
	localparam logic [pvps_pkg::SOC_W-1:0]          SOC_MID = 16'd32768;

	localparam longint ALPHA_ONE = longint'(1) << pvps_pkg::ALPHA_W;
	localparam longint HALF_LSB  = longint'(1) << (pvps_pkg::FRAC_W - 1);

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int END_WAIT_CYCLES = 100;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [pvps_pkg::CFG_IDX_W-1:0]      cfg_index = pvps_pkg::CFG_ALPHA;
	logic [pvps_pkg::CFG_W-1:0]          cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic signed [pvps_pkg::POWER_W-1:0] pv_power = '0;
	logic [pvps_pkg::SOC_W-1:0]          soc = '0;
	logic [pvps_pkg::LIMIT_W-1:0]        charge_limit = '0;
	logic [pvps_pkg::LIMIT_W-1:0]        discharge_limit = '0;
	logic                                charge_enable = 1'b0;
	logic                                discharge_enable = 1'b0;
	logic                                smoothing_enable = 1'b0;
	logic                                sample_valid = 1'b0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [pvps_pkg::POWER_W-1:0] compensation_power;

	// Predictor copy of the configuration and of the filter state.
	logic [pvps_pkg::CFG_W-1:0] alpha_cfg    = pvps_pkg::ALPHA_RST;
	logic [pvps_pkg::CFG_W-1:0] soc_min_cfg  = pvps_pkg::SOC_MIN_RST;
	logic [pvps_pkg::CFG_W-1:0] soc_low_cfg  = pvps_pkg::SOC_LOW_RST;
	logic [pvps_pkg::CFG_W-1:0] soc_high_cfg = pvps_pkg::SOC_HIGH_RST;
	logic [pvps_pkg::CFG_W-1:0] soc_max_cfg  = pvps_pkg::SOC_MAX_RST;
	longint                     filt_state = 0;
	bit                         filt_reload = 1'b1;

	logic signed [pvps_pkg::POWER_W-1:0] expected_comp_q[$];
	logic signed [pvps_pkg::POWER_W-1:0] head_comp;
	logic signed [pvps_pkg::POWER_W-1:0] pv_level = '0;
	int                                  error_count = 0;
	int                                  stall_cycles = 0;
	bit                                  idle_on = 1'b1;

	pv_power_smoothing_controller_top i_dut (.*);

	always #2 clk = ~clk;

	// Saturates a value to a signed range of the given width.
	function automatic longint clamp_signed(input longint v, input int w);
		longint hi;
		hi = (longint'(1) <<< (w - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// Scales a command by num/den; zero when the ratio is negative, zero or undefined.
	function automatic longint derated(input longint c, input longint num, input longint den);
		longint mag;
		if (den == 0 || num == 0 || ((num < 0) != (den < 0))) return 0;
		mag = (c < 0 ? -c : c) * (num < 0 ? -num : num) / (den < 0 ? -den : den);
		return c < 0 ? -mag : mag;
	endfunction

	// Advances the filter by one sample and returns the expected battery command.
	function automatic logic signed [pvps_pkg::POWER_W-1:0] predict_compensation(
		input sample_t s);
		longint pf, acc, c, r, soc_v;
		pf = longint'($signed(s.pv_power)) * (longint'(1) << pvps_pkg::FRAC_W);
		soc_v = longint'(s.soc);
		if (!s.sample_valid || !s.smoothing_enable) begin
			filt_state = pf;
			filt_reload = 1'b1;
			return '0;
		end
		if (filt_reload) begin
			filt_state = pf;
			filt_reload = 1'b0;
			return '0;
		end
		acc = longint'(alpha_cfg) * filt_state +
			(ALPHA_ONE - longint'(alpha_cfg)) * pf + HALF_LSB;
		filt_state = clamp_signed(acc >>> pvps_pkg::FRAC_W, pvps_pkg::STATE_W);
		c = filt_state - pf;
		// Derate charging near full and discharging near empty.
		if (soc_v > longint'(soc_high_cfg) && c < 0)
			c = derated(c, longint'(soc_max_cfg) - soc_v,
				longint'(soc_max_cfg) - longint'(soc_high_cfg));
		else if (soc_v < longint'(soc_low_cfg) && c > 0)
			c = derated(c, soc_v - longint'(soc_min_cfg),
				longint'(soc_low_cfg) - longint'(soc_min_cfg));
		// Round to whole power units, half away from zero.
		r = ((c < 0 ? -c : c) + HALF_LSB) >>> pvps_pkg::FRAC_W;
		if (c < 0) r = -r;
		// Per-direction limits and gates.
		if (r < 0) begin
			if (!s.charge_enable) r = 0;
			else if (r < -longint'(s.charge_limit)) r = -longint'(s.charge_limit);
		end else begin
			if (!s.discharge_enable) r = 0;
			else if (r > longint'(s.discharge_limit)) r = longint'(s.discharge_limit);
		end
		r = clamp_signed(r, pvps_pkg::POWER_W);
		return r[pvps_pkg::POWER_W-1:0];
	endfunction

	// Drives one sample transaction and records its expected command once accepted.
	task automatic send_sample(input sample_t s);
		while (idle_on && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		pv_power         <= s.pv_power;
		soc              <= s.soc;
		charge_limit     <= s.charge_limit;
		discharge_limit  <= s.discharge_limit;
		charge_enable    <= s.charge_enable;
		discharge_enable <= s.discharge_enable;
		smoothing_enable <= s.smoothing_enable;
		sample_valid     <= s.sample_valid;
		do @(posedge clk); while (!in_ready);
		expected_comp_q.push_back(predict_compensation(s));
	endtask

	task automatic send_directed(input logic signed [pvps_pkg::POWER_W-1:0] pv,
		input logic [pvps_pkg::SOC_W-1:0] sv, input logic [pvps_pkg::LIMIT_W-1:0] chg,
		input logic [pvps_pkg::LIMIT_W-1:0] dis, input logic [3:0] en);
		sample_t s;
		s.pv_power = pv;
		s.soc = sv;
		s.charge_limit = chg;
		s.discharge_limit = dis;
		{s.sample_valid, s.smoothing_enable, s.charge_enable, s.discharge_enable} = en;
		send_sample(s);
	endtask

	// Stops the sender and waits until every expected command has arrived.
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_comp_q.size() != 0);
	endtask

	task automatic write_cfg(input logic [pvps_pkg::CFG_IDX_W-1:0] idx,
		input logic [pvps_pkg::CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Writes all five registers back to back; the block must be idle.
	task automatic apply_settings(input logic [pvps_pkg::CFG_W-1:0] alpha,
		input logic [pvps_pkg::CFG_W-1:0] smin, input logic [pvps_pkg::CFG_W-1:0] slow,
		input logic [pvps_pkg::CFG_W-1:0] shigh, input logic [pvps_pkg::CFG_W-1:0] smax);
		write_cfg(pvps_pkg::CFG_ALPHA, alpha);
		write_cfg(pvps_pkg::CFG_SOC_MIN, smin);
		write_cfg(pvps_pkg::CFG_SOC_LOW, slow);
		write_cfg(pvps_pkg::CFG_SOC_HIGH, shigh);
		write_cfg(pvps_pkg::CFG_SOC_MAX, smax);
		cfg_we <= 1'b0;
		alpha_cfg    = alpha;
		soc_min_cfg  = smin;
		soc_low_cfg  = slow;
		soc_high_cfg = shigh;
		soc_max_cfg  = smax;
	endtask

	// Mostly valid, smoothed samples so the filter keeps running; some reloads mixed in.
	function automatic sample_t random_sample();
		sample_t s;
		s.sample_valid     = ($urandom_range(99) >= 4);
		s.smoothing_enable = ($urandom_range(99) >= 3);
		s.charge_enable    = ($urandom_range(99) >= 10);
		s.discharge_enable = ($urandom_range(99) >= 10);
		case ($urandom_range(3))
			0: s.pv_power = pvps_pkg::POWER_W'($urandom);
			1: s.pv_power = pvps_pkg::POWER_W'($urandom_range(0, 2000) - 1000);
			default: begin
				pv_level = pv_level +
					$signed(pvps_pkg::POWER_W'($urandom_range(0, 400000) - 200000));
				s.pv_power = pv_level;
			end
		endcase
		case ($urandom_range(3))
			0: s.soc = soc_high_cfg + pvps_pkg::SOC_W'($urandom_range(0, 600) - 300);
			1: s.soc = soc_low_cfg + pvps_pkg::SOC_W'($urandom_range(0, 600) - 300);
			default: s.soc = pvps_pkg::SOC_W'($urandom);
		endcase
		s.charge_limit    = $urandom_range(1) ? pvps_pkg::LIMIT_W'($urandom) :
			pvps_pkg::LIMIT_W'($urandom_range(0, 50000));
		s.discharge_limit = $urandom_range(1) ? pvps_pkg::LIMIT_W'($urandom) :
			pvps_pkg::LIMIT_W'($urandom_range(0, 50000));
		return s;
	endfunction

	// Filter loading, reloads, limits and direction gates under the reset settings.
	task automatic test_filter_and_limits();
		send_directed(PV_MAX, SOC_MID, LIM_MAX, LIM_MAX, EN_NO_VALID);
		send_directed(PV_MAX, SOC_MID, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(PV_MIN, SOC_MID, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(PV_MAX, SOC_MID, '0, LIM_MAX, EN_ALL);
		send_directed(PV_MIN, SOC_MID, LIM_MAX, '0, EN_ALL);
		send_directed(PV_MAX, SOC_MID, LIM_MAX, LIM_MAX, EN_NO_CHG);
		send_directed(PV_MIN, SOC_MID, LIM_MAX, LIM_MAX, EN_NO_DIS);
		send_directed(24'sd100, SOC_MID, LIM_MAX, LIM_MAX, EN_NO_SMOOTH);
		send_directed(-24'sd5000, SOC_MID, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(24'sd5000, SOC_MID, LIM_MAX, LIM_MAX, EN_ALL);
	endtask

	// Charge and discharge derating inside, at and beyond the SOC thresholds.
	task automatic test_soc_derating();
		send_directed(24'sd0, SOC_MID, LIM_MAX, LIM_MAX, EN_NO_VALID);
		send_directed(24'sd0, SOC_MID, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(24'sd2000000, 16'd55000, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(24'sd0, 16'd10000, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(24'sd4000000, 16'hFFFF, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(24'sd0, 16'd0, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(24'sd3000000, pvps_pkg::SOC_MAX_RST, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(24'sd0, pvps_pkg::SOC_MIN_RST, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(24'sd3000000, pvps_pkg::SOC_HIGH_RST, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(24'sd0, pvps_pkg::SOC_LOW_RST, LIM_MAX, LIM_MAX, EN_ALL);
	endtask

	// Zero derating span and inverted thresholds.
	task automatic test_threshold_corners();
		wait_results_drained();
		apply_settings(16'hFFFF, 16'd20000, 16'd20000, 16'd40000, 16'd40000);
		send_directed(24'sd0, SOC_MID, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(24'sd1000000, 16'd50000, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(-24'sd1000000, 16'd10000, LIM_MAX, LIM_MAX, EN_ALL);
		wait_results_drained();
		apply_settings(16'd32768, 16'd30000, 16'd10000, 16'd50000, 16'd30000);
		send_directed(24'sd0, SOC_MID, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(24'sd2000000, 16'd60000, LIM_MAX, LIM_MAX, EN_ALL);
		send_directed(-24'sd2000000, 16'd5000, LIM_MAX, LIM_MAX, EN_ALL);
	endtask

	// One random phase under fixed settings, with a full drain part way through and at random points.
	task automatic run_random_phase(input int count, input bit with_idle,
		input logic [pvps_pkg::CFG_W-1:0] alpha, input logic [pvps_pkg::CFG_W-1:0] smin,
		input logic [pvps_pkg::CFG_W-1:0] slow, input logic [pvps_pkg::CFG_W-1:0] shigh,
		input logic [pvps_pkg::CFG_W-1:0] smax);
		wait_results_drained();
		apply_settings(alpha, smin, slow, shigh, smax);
		idle_on = with_idle;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2 || $urandom_range(39) == 0) wait_results_drained();
			send_sample(random_sample());
		end
	endtask

	task automatic test_random_traffic();
		logic [pvps_pkg::CFG_W-1:0] smin, slow, shigh;
		run_random_phase(100, 1'b1, pvps_pkg::ALPHA_RST, pvps_pkg::SOC_MIN_RST,
			pvps_pkg::SOC_LOW_RST, pvps_pkg::SOC_HIGH_RST, pvps_pkg::SOC_MAX_RST);
		smin  = pvps_pkg::CFG_W'($urandom_range(0, 20000));
		slow  = smin + pvps_pkg::CFG_W'($urandom_range(0, 20000));
		shigh = slow + pvps_pkg::CFG_W'($urandom_range(0, 12000));
		run_random_phase(100, 1'b1, pvps_pkg::CFG_W'($urandom), smin, slow, shigh,
			shigh + pvps_pkg::CFG_W'($urandom_range(0, 13535)));
		run_random_phase(40, 1'b1, '0, '0, '1, '0, '1);
		run_random_phase(100, 1'b1, '1, '1, '0, '1, '0);
		run_random_phase(100, 1'b0, pvps_pkg::CFG_W'($urandom), pvps_pkg::CFG_W'($urandom),
			pvps_pkg::CFG_W'($urandom), pvps_pkg::CFG_W'($urandom),
			pvps_pkg::CFG_W'($urandom));
		smin  = pvps_pkg::CFG_W'($urandom_range(0, 20000));
		slow  = smin + pvps_pkg::CFG_W'($urandom_range(0, 20000));
		shigh = slow + pvps_pkg::CFG_W'($urandom_range(0, 12000));
		run_random_phase(60, 1'b1, pvps_pkg::CFG_W'($urandom_range(60000, 65535)), smin,
			slow, shigh, shigh + pvps_pkg::CFG_W'($urandom_range(0, 13535)));
	endtask

	// Compare each result transaction with the oldest expected command.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_comp_q.size() == 0) begin
					$error("compensation_power: expected none, actual %0d", compensation_power);
					error_count++;
				end else begin
					head_comp = expected_comp_q.pop_front();
					if (compensation_power !== head_comp) begin
						$error("compensation_power: expected %0d, actual %0d",
							head_comp, compensation_power);
						error_count++;
					end
				end
			end
			out_ready <= !(idle_on && $urandom_range(99) < 8);
		end
	end

	// End the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("** pv_power_smoothing_controller_top: FAILED **");
					$finish;
				end
			end
		end
	end

	// Reset, run the tests in turn, drain and report.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_filter_and_limits();
		test_soc_derating();
		test_threshold_corners();
		test_random_traffic();
		wait_results_drained();
		repeat (END_WAIT_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_comp_q.size() == 0) begin
			$display("** pv_power_smoothing_controller_top: PASSED **");
		end else begin
			$display("** pv_power_smoothing_controller_top: FAILED **");
		end
		$finish;
	end

endmodule
